>>> design/tce_pkg.sv
// Shared constants for the transitive closure engine.
package tce_pkg;

   localparam int ROW_W      = 32;
   localparam int ROW_IDX_W  = 5;
   localparam int ROW_NUM_W  = 5;
   localparam int NODE_CNT_W = 6;
   localparam int NODE_HW_CAP = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_NODE_COUNT = 1'b0;

   localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 6'd32;

endpackage

>>> design/tce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tce_csr.sv
// APB configuration register block: node count.
module tce_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tce_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tce_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tce_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [tce_pkg::NODE_CNT_W-1:0]  node_count
);

   logic [tce_pkg::NODE_CNT_W-1:0] node_count_ff;
   logic [tce_pkg::NODE_CNT_W-1:0] node_count_in;
   logic                           reg_idx;
   logic                           wr_hit;

   assign reg_idx = csr_paddr[2];
   assign wr_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      node_count_in = node_count_ff;
      if (wr_hit && reg_idx == tce_pkg::CSR_IDX_NODE_COUNT) begin
         node_count_in = csr_pwdata[tce_pkg::NODE_CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= tce_pkg::NODE_COUNT_RST;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         tce_pkg::CSR_IDX_NODE_COUNT: begin
            csr_prdata = tce_pkg::CSR_DATA_W'(node_count_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready = 1'b1;
   assign node_count = node_count_ff;

endmodule

>>> design/tce_seq.sv
// Row loader, Warshall pivot sweeps and closure readout around the row RAM.
module tce_seq #(
   parameter int NODE_LIMIT = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tce_pkg::NODE_CNT_W-1:0]  node_count,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tce_pkg::ROW_W-1:0]       req_row_bits,
   input  logic                            req_last_row,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tce_pkg::ROW_NUM_W-1:0]   rsp_row_number,
   output logic [tce_pkg::ROW_W-1:0]       rsp_closure_bits,
   output logic                            rsp_last_result
);

   localparam int IW  = $clog2(NODE_LIMIT);
   localparam int IW1 = IW + 1;
   localparam int CW  = $clog2(NODE_LIMIT + 1);
   localparam int RIW = tce_pkg::ROW_IDX_W;
   localparam int RW  = tce_pkg::ROW_W;
   localparam int NW  = tce_pkg::ROW_NUM_W;
   localparam logic [tce_pkg::NODE_CNT_W-1:0] NL_CFG = tce_pkg::NODE_CNT_W'(NODE_LIMIT);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_PIV0  = 3'd1;
   localparam logic [2:0] ST_PIV1  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] rows_loaded_ff, rows_loaded_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] k_ff, k_in;
   logic          wb_valid_ff, wb_valid_in;
   logic [IW-1:0] wb_row_ff, wb_row_in;
   logic [IW-1:0] wb_k_ff, wb_k_in;
   logic [RW-1:0] pivot_ff, pivot_in;
   logic [RW-1:0] next_pivot_ff, next_pivot_in;
   logic          em_pend_ff, em_pend_in;
   logic [IW-1:0] em_row_ff, em_row_in;
   logic          em_last_ff, em_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_row_ff, rsp_row_in;
   logic [RW-1:0] rsp_bits_ff, rsp_bits_in;
   logic          rsp_last_ff, rsp_last_in;

   logic                           mem_we;
   logic [IW-1:0]                  mem_waddr;
   logic [RW-1:0]                  mem_wdata;
   logic                           mem_re;
   logic [IW-1:0]                  mem_raddr;
   logic [RW-1:0]                  mem_rdata;

   logic [tce_pkg::NODE_CNT_W-1:0] n_sat;
   logic [CW-1:0]                  n_live;
   logic [CW-1:0]                  n_m1;
   logic [IW-1:0]                  last_idx;
   logic [RW-1:0]                  col_mask;
   logic [RW-1:0]                  wb_clean;
   logic [RW-1:0]                  wb_upd;
   logic                           wb_is_next;
   logic                           req_fire;
   logic                           emit_slot;

   tce_ram #(
      .WIDTH (RW),
      .DEPTH (NODE_LIMIT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      if (node_count == '0) begin
         n_sat = tce_pkg::NODE_CNT_W'(1);
      end else if (node_count > NL_CFG) begin
         n_sat = NL_CFG;
      end else begin
         n_sat = node_count;
      end
   end

   assign n_live   = n_sat[CW-1:0];
   assign n_m1     = n_ff - CW'(1);
   assign last_idx = n_m1[IW-1:0];

   always_comb begin
      for (int j = 0; j < RW; j++) begin
         col_mask[j] = (j < int'(n_ff));
      end
   end

   // every pass trims columns; pass 0 also zeroes rows that were never loaded
   always_comb begin
      if (wb_k_ff == '0 && CW'(wb_row_ff) >= rows_loaded_ff) begin
         wb_clean = '0;
      end else begin
         wb_clean = mem_rdata & col_mask;
      end
      wb_upd     = wb_clean[RIW'(wb_k_ff)] ? (wb_clean | pivot_ff) : wb_clean;
      wb_is_next = IW1'(wb_row_ff) == (IW1'(wb_k_ff) + IW1'(1));
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign emit_slot = !em_pend_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      rows_loaded_in = rows_loaded_ff;
      i_in           = i_ff;
      k_in           = k_ff;
      wb_valid_in    = 1'b0;
      wb_row_in      = wb_row_ff;
      wb_k_in        = wb_k_ff;
      pivot_in       = pivot_ff;
      next_pivot_in  = next_pivot_ff;
      em_pend_in     = 1'b0;
      em_row_in      = em_row_ff;
      em_last_in     = em_last_ff;
      mem_we         = 1'b0;
      mem_waddr      = wb_row_ff;
      mem_wdata      = wb_upd;
      mem_re         = 1'b0;
      mem_raddr      = i_ff;

      if (wb_valid_ff) begin
         mem_we = 1'b1;
         if (wb_is_next) begin
            next_pivot_in = wb_upd;
         end
         if (wb_row_ff == last_idx) begin
            pivot_in = wb_is_next ? wb_upd : next_pivot_ff;
         end
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (rows_loaded_ff < n_live) begin
                  mem_we         = 1'b1;
                  mem_waddr      = rows_loaded_ff[IW-1:0];
                  mem_wdata      = req_row_bits;
                  rows_loaded_in = rows_loaded_ff + CW'(1);
               end
               if (req_last_row) begin
                  n_in     = n_live;
                  state_in = ST_PIV0;
               end
            end
         end
         ST_PIV0: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = ST_PIV1;
         end
         ST_PIV1: begin
            pivot_in = (rows_loaded_ff == '0) ? '0 : (mem_rdata & col_mask);
            i_in     = '0;
            k_in     = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            mem_re      = 1'b1;
            mem_raddr   = i_ff;
            wb_valid_in = 1'b1;
            wb_row_in   = i_ff;
            wb_k_in     = k_ff;
            if (i_ff == last_idx) begin
               i_in = '0;
               if (k_ff == last_idx) begin
                  state_in = ST_DRAIN;
               end else begin
                  k_in = k_ff + IW'(1);
               end
            end else begin
               i_in = i_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_slot) begin
               mem_re     = 1'b1;
               mem_raddr  = i_ff;
               em_pend_in = 1'b1;
               em_row_in  = i_ff;
               em_last_in = (i_ff == last_idx);
               if (i_ff == last_idx) begin
                  i_in           = '0;
                  rows_loaded_in = '0;
                  state_in       = ST_LOAD;
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;
      if (em_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = NW'(em_row_ff);
         rsp_bits_in  = mem_rdata;
         rsp_last_in  = em_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         n_ff           <= CW'(1);
         rows_loaded_ff <= '0;
         i_ff           <= '0;
         k_ff           <= '0;
         wb_valid_ff    <= 1'b0;
         em_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         n_ff           <= n_in;
         rows_loaded_ff <= rows_loaded_in;
         i_ff           <= i_in;
         k_ff           <= k_in;
         wb_valid_ff    <= wb_valid_in;
         em_pend_ff     <= em_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_row_ff     <= wb_row_in;
      wb_k_ff       <= wb_k_in;
      pivot_ff      <= pivot_in;
      next_pivot_ff <= next_pivot_in;
      em_row_ff     <= em_row_in;
      em_last_ff    <= em_last_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_number   = rsp_row_ff;
   assign rsp_closure_bits = rsp_bits_ff;
   assign rsp_last_result  = rsp_last_ff;

   // readout data only lands in an empty output word
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      em_pend_ff |-> !rsp_valid_ff)
      else $error("readout word landed on a full output register");

   a_wb_from_sweep: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> $past(state_ff) == ST_SWEEP)
      else $error("row write-back without a sweep read");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (em_pend_ff && em_last_ff) |-> (state_ff == ST_LOAD && rows_loaded_ff == '0))
      else $error("final closure row read but run not closed");

endmodule

>>> design/transitive_closure_engine_unit.sv
// After the last row word: pivot row 0 read, n pivot passes, then closure rows go out.
// Throughput: one row word per cycle while loading; closure rows are read one at a time,
// each waiting for a free output register. Each pivot pass reads and rewrites all n rows.
// A row is read while the previous row's update is written back to the row RAM.
// Reset: node_count returns to 32, the row count to zero; the row RAM is not cleared.
module transitive_closure_engine_unit #(
   parameter int MAX_NODES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tce_pkg::ROW_W-1:0]       req_row_bits,
   input  logic                            req_last_row,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tce_pkg::ROW_NUM_W-1:0]   rsp_row_number,
   output logic [tce_pkg::ROW_W-1:0]       rsp_closure_bits,
   output logic                            rsp_last_result,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tce_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tce_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tce_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int NODE_LIMIT = (MAX_NODES < tce_pkg::NODE_HW_CAP) ?
                               MAX_NODES : tce_pkg::NODE_HW_CAP;

   logic [tce_pkg::NODE_CNT_W-1:0] node_count;

   tce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .node_count  (node_count)
   );

   tce_seq #(
      .NODE_LIMIT (NODE_LIMIT)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .node_count       (node_count),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_row_bits     (req_row_bits),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_number   (rsp_row_number),
      .rsp_closure_bits (rsp_closure_bits),
      .rsp_last_result  (rsp_last_result)
   );

endmodule
